/* hw/rtl/lbw_pkg.sv */
package lbw_pkg;

    localparam int MaxBeams = 4096;
    localparam int IdxW     = 12;

    localparam logic [15:0] TrigA = 16'd25736;
    localparam logic [15:0] TrigB = 16'd10512;
    localparam logic [15:0] TrigC = 16'd1160;

    localparam logic signed [17:0] RearXNear = -18'sd307;
    localparam logic signed [17:0] RearXFar  = -18'sd717;
    localparam logic signed [17:0] RearHalfW = 18'sd287;

    localparam logic [2:0] RegMinRange = 3'd0;
    localparam logic [2:0] RegMaxRange = 3'd1;
    localparam logic [2:0] RegStart    = 3'd2;
    localparam logic [2:0] RegStep     = 3'd3;
    localparam logic [2:0] RegPoseX    = 3'd4;
    localparam logic [2:0] RegPoseY    = 3'd5;
    localparam logic [2:0] RegHeading  = 3'd6;

    typedef struct packed {
        logic [IdxW-1:0] beam_index;
        logic [15:0]     beam_range;
        logic            range_bad;
    } beam_t;

    typedef struct packed {
        logic        kept;
        logic [31:0] world_x;
        logic [31:0] world_y;
        logic [15:0] range_out;
    } point_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] data;
    } cfg_t;

    typedef struct packed {
        logic [15:0]        min_range;
        logic [15:0]        max_range;
        logic [15:0]        start_angle;
        logic signed [15:0] angle_step;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic [15:0]        pose_heading;
    } regs_t;

    typedef struct packed {
        logic        neg;
        logic [14:0] x;
    } fold_t;

    function automatic fold_t fold_angle(input logic [15:0] a);
        fold_t f;
        logic [14:0] h;
        h = a[14:0];
        f.neg = a[15];
        f.x = (h > 15'd16384) ? 15'(16'd32768 - {1'b0, h}) : h;
        return f;
    endfunction

    function automatic logic signed [17:0] round_scale(input logic [15:0] rng,
                                                        input logic neg,
                                                        input logic [14:0] mag);
        logic [30:0] p;
        logic [16:0] r;
        p = rng * mag;
        r = 17'((31'(p) + 31'd8192) >> 14);
        return neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    endfunction

endpackage

/* hw/rtl/lbw_if.sv */
interface lbw_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hw/rtl/lbw_regs.sv */
module lbw_regs
    import lbw_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    lbw_if.sink   cfg,
    output regs_t regs
);
    regs_t regs_reg;

    assign cfg.ready = 1'b1;
    assign regs = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '{min_range: 16'd0, max_range: 16'hFFFF, start_angle: 16'd0,
                          angle_step: 16'sd0, pose_x: 32'sd0, pose_y: 32'sd0,
                          pose_heading: 16'd0};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.data.index)
                RegMinRange: regs_reg.min_range    <= cfg.data.data[15:0];
                RegMaxRange: regs_reg.max_range    <= cfg.data.data[15:0];
                RegStart:    regs_reg.start_angle  <= cfg.data.data[15:0];
                RegStep:     regs_reg.angle_step   <= $signed(cfg.data.data[15:0]);
                RegPoseX:    regs_reg.pose_x       <= $signed(cfg.data.data);
                RegPoseY:    regs_reg.pose_y       <= $signed(cfg.data.data);
                RegHeading:  regs_reg.pose_heading <= cfg.data.data[15:0];
                default:     ;
            endcase
        end
    end
endmodule

/* hw/rtl/lbw_sin.sv */
module lbw_sin
    import lbw_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] angle,
    output logic        neg,
    output logic [14:0] mag
);
    // four registered steps of the quarter-wave polynomial
    fold_t       f;
    logic [14:0] x1_reg, x2s_reg, x3_reg, x4_reg;
    logic [15:0] x2_reg, x2b_reg;
    logic [15:0] t_reg;
    logic [15:0] t2_reg;
    logic [3:0]  n_reg;
    logic [31:0] p1, p2, p3, p4;
    logic [15:0] x2_next, t_next, t2_next;
    logic [14:0] s_next;

    assign f = fold_angle(angle);
    assign p1 = f.x * f.x;
    assign x2_next = 16'(p1 >> 14);
    assign p2 = TrigC * x2_reg;
    assign t_next = TrigB - 16'(p2 >> 14);
    assign p3 = x2b_reg * t_reg;
    assign t2_next = TrigA - 16'(p3 >> 14);
    assign p4 = x3_reg * t2_reg;
    assign s_next = 15'(p4 >> 14);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= f.x;
            x2_reg  <= x2_next;
            x2s_reg <= x1_reg;
            x2b_reg <= x2_reg;
            t_reg   <= t_next;
            x3_reg  <= x2s_reg;
            t2_reg  <= t2_next;
            x4_reg  <= s_next;
            n_reg   <= {n_reg[2:0], f.neg};
        end
    end

    assign neg = n_reg[3];
    assign mag = x4_reg;
endmodule

/* hw/rtl/laser_beam_to_world_point_unit.sv */
// channel | dir | payload
// beam    | in  | beam_index, beam_range, range_bad
// point   | out | kept, world_x, world_y, range_out
// cfg     | in  | index, data (always ready)
// One request per cycle while the output is not stalled; the result passes eight register
// stages, including those of the four-step polynomial units.
// Reset clears valid bits and registers; payload carries no reset.
// Stalls freeze the whole pipeline while the output register is full and not taken.
module laser_beam_to_world_point_unit
    import lbw_pkg::*;
(
    input logic clk,
    input logic rst_n,
    lbw_if.sink   beam,
    lbw_if.source point,
    lbw_if.sink   cfg
);
    localparam int Depth = 8;

    regs_t regs;
    logic  en;
    logic [Depth-1:0] v_reg;
    logic [15:0] ang_reg, gang_reg;
    logic        ok_reg;
    logic [15:0] rng_reg;
    logic [27:0] prod;
    logic        ok_next;
    logic [3:0]  okd_reg;
    logic [15:0] rd_reg [4];
    logic        bc_n, bs_n, wc_n, ws_n;
    logic [14:0] bc_m, bs_m, wc_m, ws_m;
    logic signed [17:0] px_reg, py_reg, wx_reg, wy_reg;
    logic        ok6_reg, ok7_reg;
    logic [15:0] r6_reg, r7_reg;
    logic signed [33:0] sx_reg, sy_reg;
    logic        drop;
    point_t      out_reg;

    lbw_regs u_regs (.clk(clk), .rst_n(rst_n), .cfg(cfg), .regs(regs));

    assign en = !point.valid || point.ready;
    assign beam.ready = en;
    assign point.valid = v_reg[Depth-1];
    assign point.data = out_reg;

    assign prod = 28'($signed({1'b0, beam.data.beam_index}) * regs.angle_step);
    assign ok_next = !beam.data.range_bad && (32'(beam.data.beam_index) < 32'(MaxBeams))
                     && beam.data.beam_range >= regs.min_range
                     && beam.data.beam_range <= regs.max_range;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[Depth-2:0], beam.valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg  <= regs.start_angle + prod[15:0];
            gang_reg <= regs.start_angle + prod[15:0] + regs.pose_heading;
            ok_reg   <= ok_next;
            rng_reg  <= beam.data.beam_range;
            okd_reg  <= {okd_reg[2:0], ok_reg};
            rd_reg[0] <= rng_reg;
            for (int i = 1; i < 4; i++)
                rd_reg[i] <= rd_reg[i-1];
            px_reg  <= round_scale(rd_reg[3], bc_n, bc_m);
            py_reg  <= round_scale(rd_reg[3], bs_n, bs_m);
            wx_reg  <= round_scale(rd_reg[3], wc_n, wc_m);
            wy_reg  <= round_scale(rd_reg[3], ws_n, ws_m);
            ok6_reg <= okd_reg[3];
            r6_reg  <= rd_reg[3];
            ok7_reg <= ok6_reg && !drop;
            r7_reg  <= r6_reg;
            sx_reg <= 34'(regs.pose_x) + 34'(wx_reg);
            sy_reg <= 34'(regs.pose_y) + 34'(wy_reg);
            out_reg.kept <= ok7_reg;
            out_reg.range_out <= ok7_reg ? r7_reg : 16'd0;
            out_reg.world_x <= !ok7_reg ? 32'd0 :
                (sx_reg > 34'sh7FFFFFFF) ? 32'h7FFFFFFF :
                (sx_reg < -34'sh80000000) ? 32'h80000000 : sx_reg[31:0];
            out_reg.world_y <= !ok7_reg ? 32'd0 :
                (sy_reg > 34'sh7FFFFFFF) ? 32'h7FFFFFFF :
                (sy_reg < -34'sh80000000) ? 32'h80000000 : sy_reg[31:0];
        end
    end

    assign drop = px_reg < RearXNear && px_reg > RearXFar
                  && py_reg < RearHalfW && py_reg > -RearHalfW;

    lbw_sin u_bc (.clk(clk), .en(en), .angle(ang_reg + 16'd16384), .neg(bc_n), .mag(bc_m));
    lbw_sin u_bs (.clk(clk), .en(en), .angle(ang_reg), .neg(bs_n), .mag(bs_m));
    lbw_sin u_wc (.clk(clk), .en(en), .angle(gang_reg + 16'd16384), .neg(wc_n), .mag(wc_m));
    lbw_sin u_ws (.clk(clk), .en(en), .angle(gang_reg), .neg(ws_n), .mag(ws_m));

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && !point.ready |=> point.valid && $stable(point.data))
        else $error("result lost under stall");
    a_drop: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && !point.data.kept |-> point.data.world_x == 32'd0
        && point.data.range_out == 16'd0)
        else $error("dropped beam carries data");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        beam.valid && beam.ready |=> v_reg[0])
        else $error("accepted beam has no valid bit");
endmodule
